// ----- rtl/wsd_pkg.sv -----
// shared types, constants and helper functions of the wav to dac sample block
`default_nettype none

package wsd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned VOL_W  = 8;
  localparam int unsigned DAC_W  = 12;
  localparam int unsigned CNT_W  = $clog2(DAC_W);

  localparam logic [5:0] POS_CHANNELS = 6'd23;
  localparam logic [5:0] POS_BITS     = 6'd35;
  localparam logic [5:0] POS_LAST     = 6'd43;

  typedef enum logic [1:0] {
    KIND_FRAME = 2'd0,
    KIND_TAG   = 2'd1,
    KIND_FMT   = 2'd2
  } kind_e;

  typedef struct packed {
    logic              en;
    logic [BYTE_W-1:0] chr;
  } tag_check_t;

  localparam logic [15:0][BYTE_W-1:0] TAG_CHARS = {
    8'h61, 8'h74, 8'h61, 8'h64,   // "data"
    8'h20, 8'h74, 8'h6d, 8'h66,   // "fmt "
    8'h45, 8'h56, 8'h41, 8'h57,   // "WAVE"
    8'h46, 8'h46, 8'h49, 8'h52    // "RIFF"
  };

  // expected tag character at a header position
  function automatic tag_check_t tag_expect(input logic [5:0] pos);
    tag_check_t r;
    logic [5:0] idx;
    r.en = 1'b1;
    idx  = 6'd0;
    case (pos) inside
      [6'd0:6'd3]:   idx = pos;
      [6'd8:6'd15]:  idx = pos - 6'd4;
      [6'd36:6'd39]: idx = pos - 6'd24;
      default:       r.en = 1'b0;
    endcase
    r.chr = TAG_CHARS[idx[3:0]];
    return r;
  endfunction

  // signed 16-bit sample reduced to 12-bit offset binary
  function automatic logic [DAC_W-1:0] scale_wide(input logic [BYTE_W-1:0] lo,
                                                  input logic [BYTE_W-1:0] hi);
    return {~hi[7], hi[6:0], lo[7:4]};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/wsd_in_if.sv -----
// input byte channel of the wav to dac sample block
`default_nettype none

interface wsd_in_if;
  logic                      valid;
  logic                      ready;
  logic [wsd_pkg::BYTE_W-1:0] data_byte;
  logic                      file_start;

  modport source (output valid, output data_byte, output file_start, input ready);
  modport sink   (input valid, input data_byte, input file_start, output ready);
endinterface

`default_nettype wire

// ----- rtl/wsd_out_if.sv -----
// result channel of the wav to dac sample block
`default_nettype none

interface wsd_out_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               kind;
  logic [wsd_pkg::DAC_W-1:0] left_value;
  logic [wsd_pkg::DAC_W-1:0] right_value;
  logic                     align_left;
  logic                     last_frame;

  modport source (output valid, output kind, output left_value, output right_value,
                  output align_left, output last_frame, input ready);
  modport sink   (input valid, input kind, input left_value, input right_value,
                  input align_left, input last_frame, output ready);
endinterface

`default_nettype wire

// ----- rtl/wsd_div.sv -----
// iterative restoring divider, one quotient bit per cycle
`default_nettype none

module wsd_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [wsd_pkg::DAC_W-1:0]  dividend_i,
  input  logic [wsd_pkg::VOL_W-1:0]  divisor_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic [wsd_pkg::DAC_W-1:0]  quot_o
);

  logic                      busy_q, done_q;
  logic [wsd_pkg::CNT_W-1:0] cnt_q;
  logic [wsd_pkg::VOL_W-1:0] rem_q, rem_d, dvs_q;
  logic [wsd_pkg::DAC_W-1:0] quo_q;
  logic [wsd_pkg::VOL_W:0]   trial, diff;
  logic                      ge;

  always_comb begin
    trial = {rem_q, quo_q[wsd_pkg::DAC_W-1]};
    diff  = trial - {1'b0, dvs_q};
    ge    = (trial >= {1'b0, dvs_q});
    rem_d = ge ? diff[wsd_pkg::VOL_W-1:0] : trial[wsd_pkg::VOL_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= wsd_pkg::CNT_W'(wsd_pkg::DAC_W - 1);
        rem_q  <= '0;
        dvs_q  <= divisor_i;
        quo_q  <= dividend_i;
      end else if (busy_q) begin
        rem_q <= rem_d;
        quo_q <= {quo_q[wsd_pkg::DAC_W-2:0], ge};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

`default_nettype wire

// ----- rtl/wav_stream_to_dac_samples_core.sv -----
// top level: wav header parser and frame to dac word converter
//
// Takes a canonical 44-byte wav header and then sample data, one byte per request.
// Header bytes and data bytes that do not complete a frame are taken without a stall.
// The byte that completes a frame starts the shared 12-step divider, which divides
// the left sample and, in a stereo frame, then the right one; the result then reaches
// the output register, which holds it while the next bytes are taken in. A header
// error result bypasses the divider. The block is not ready while a division runs or
// while a finished result waits for the output register.
`default_nettype none

module wav_stream_to_dac_samples_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  wsd_in_if.sink                    in_i,
  wsd_out_if.source                 out_o,
  input  logic                      cfg_we_i,
  input  logic [wsd_pkg::VOL_W-1:0] cfg_wdata_i
);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DATA   = 2'd1,
    PH_WAIT   = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_DIV_L = 2'd1,
    S_DIV_R = 2'd2,
    S_PUSH  = 2'd3
  } state_e;

  // parse state
  logic [5:0]  hpos_q, c_hpos, n_hpos;
  phase_e      phase_q, c_phase, n_phase;
  logic [31:0] shift_q, c_shift, n_shift, shift_v;
  logic        tags_q, c_tags, n_tags;
  logic        stereo_q, c_stereo, n_stereo;
  logic        wide_q, c_wide, n_wide;
  logic        fmt_q, c_fmt, n_fmt;
  logic [31:0] remain_q, c_remain, n_remain, remain_dec;
  logic [23:0] fbytes_q, c_fbytes, n_fbytes;
  logic [1:0]  fpos_q, c_fpos, n_fpos, fs_m1, fs_m1_n;
  logic [2:0]  fs, fs_n;
  logic [7:0]  b;
  logic        hdr_bad;

  wsd_pkg::tag_check_t tchk;

  logic                      in_fire, frame_done, err_en, last_n;
  wsd_pkg::kind_e            err_kind;
  logic [wsd_pkg::DAC_W-1:0] x_n, y_n;

  // sequencer and result registers
  state_e                    state_q;
  logic [wsd_pkg::VOL_W-1:0] vol_q, div_dvs;
  logic [wsd_pkg::DAC_W-1:0] y_q, res_left_q, res_right_q;
  wsd_pkg::kind_e            res_kind_q, out_kind_q;
  logic                      two_q, res_align_q, res_last_q;
  logic                      out_valid_q, out_align_q, out_last_q;
  logic [wsd_pkg::DAC_W-1:0] out_left_q, out_right_q;

  logic                      div_start, div_busy, div_done;
  logic [wsd_pkg::DAC_W-1:0] div_dividend, div_quot;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign b          = in_i.data_byte;

  always_comb begin
    if (in_i.file_start) begin
      c_hpos   = '0;
      c_phase  = PH_HEADER;
      c_shift  = '0;
      c_tags   = 1'b1;
      c_stereo = 1'b0;
      c_wide   = 1'b0;
      c_fmt    = 1'b0;
      c_remain = '0;
      c_fbytes = '0;
      c_fpos   = '0;
    end else begin
      c_hpos   = hpos_q;
      c_phase  = phase_q;
      c_shift  = shift_q;
      c_tags   = tags_q;
      c_stereo = stereo_q;
      c_wide   = wide_q;
      c_fmt    = fmt_q;
      c_remain = remain_q;
      c_fbytes = fbytes_q;
      c_fpos   = fpos_q;
    end

    n_hpos   = c_hpos;
    n_phase  = c_phase;
    n_shift  = c_shift;
    n_tags   = c_tags;
    n_stereo = c_stereo;
    n_wide   = c_wide;
    n_fmt    = c_fmt;
    n_remain = c_remain;
    n_fbytes = c_fbytes;
    n_fpos   = c_fpos;

    frame_done = 1'b0;
    err_en     = 1'b0;
    err_kind   = wsd_pkg::KIND_TAG;
    last_n     = 1'b0;
    x_n        = '0;
    y_n        = '0;
    hdr_bad    = 1'b0;
    fs_m1_n    = '0;
    fs_n       = '0;

    tchk       = wsd_pkg::tag_expect(c_hpos);
    shift_v    = {b, c_shift[31:8]};
    fs_m1      = {c_stereo & c_wide, c_stereo | c_wide};
    fs         = {1'b0, fs_m1} + 3'd1;
    remain_dec = c_remain - 32'd1;

    case (c_phase)
      PH_HEADER: begin
        if (tchk.en && (tchk.chr != b)) begin
          n_tags = 1'b0;
        end
        n_shift = shift_v;
        if (c_hpos == wsd_pkg::POS_CHANNELS) begin
          if (shift_v[31:16] == 16'd1) begin
            n_stereo = 1'b0;
          end else if (shift_v[31:16] == 16'd2) begin
            n_stereo = 1'b1;
          end else begin
            n_fmt = 1'b1;
          end
        end else if (c_hpos == wsd_pkg::POS_BITS) begin
          if (shift_v[31:16] == 16'd8) begin
            n_wide = 1'b0;
          end else if (shift_v[31:16] == 16'd16) begin
            n_wide = 1'b1;
          end else begin
            n_fmt = 1'b1;
          end
        end
        n_hpos = c_hpos + 6'd1;
        if (c_hpos == wsd_pkg::POS_LAST) begin
          hdr_bad  = !n_tags || n_fmt;
          fs_m1_n  = {n_stereo & n_wide, n_stereo | n_wide};
          fs_n     = {1'b0, fs_m1_n} + 3'd1;
          n_remain = shift_v;
          n_fbytes = '0;
          n_fpos   = '0;
          n_fmt    = 1'b0;
          if (hdr_bad) begin
            err_en   = 1'b1;
            err_kind = n_tags ? wsd_pkg::KIND_FMT : wsd_pkg::KIND_TAG;
            n_phase  = PH_WAIT;
          end else if (shift_v < {29'd0, fs_n}) begin
            n_phase = PH_WAIT;
          end else begin
            n_phase = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        n_remain = remain_dec;
        if (c_fpos != fs_m1) begin
          case (c_fpos)
            2'd0:    n_fbytes[7:0]   = c_fbytes[7:0] | b;
            2'd1:    n_fbytes[15:8]  = c_fbytes[15:8] | b;
            2'd2:    n_fbytes[23:16] = c_fbytes[23:16] | b;
            default: n_fbytes = c_fbytes;
          endcase
          n_fpos = c_fpos + 2'd1;
        end else begin
          frame_done = 1'b1;
          n_fbytes   = '0;
          n_fpos     = '0;
          last_n     = (remain_dec < {29'd0, fs});
          if (last_n) begin
            n_phase = PH_WAIT;
          end
          if (!c_wide) begin
            x_n = c_stereo ? {4'd0, c_fbytes[7:0]} : {4'd0, b};
            y_n = c_stereo ? {4'd0, b} : x_n;
          end else if (c_stereo) begin
            x_n = wsd_pkg::scale_wide(c_fbytes[7:0], c_fbytes[15:8]);
            y_n = wsd_pkg::scale_wide(c_fbytes[23:16], b);
          end else begin
            x_n = wsd_pkg::scale_wide(c_fbytes[7:0], b);
            y_n = x_n;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hpos_q   <= '0;
      phase_q  <= PH_HEADER;
      shift_q  <= '0;
      tags_q   <= 1'b1;
      stereo_q <= 1'b0;
      wide_q   <= 1'b0;
      fmt_q    <= 1'b0;
      remain_q <= '0;
      fbytes_q <= '0;
      fpos_q   <= '0;
    end else if (in_fire) begin
      hpos_q   <= n_hpos;
      phase_q  <= n_phase;
      shift_q  <= n_shift;
      tags_q   <= n_tags;
      stereo_q <= n_stereo;
      wide_q   <= n_wide;
      fmt_q    <= n_fmt;
      remain_q <= n_remain;
      fbytes_q <= n_fbytes;
      fpos_q   <= n_fpos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vol_q <= wsd_pkg::VOL_W'(1);
    end else if (cfg_we_i) begin
      vol_q <= cfg_wdata_i;
    end
  end

  // divider feed
  assign div_dvs      = (vol_q == '0) ? wsd_pkg::VOL_W'(1) : vol_q;
  assign div_start    = (state_q == S_IDLE && in_fire && frame_done)
                     || (state_q == S_DIV_L && div_done && two_q);
  assign div_dividend = (state_q == S_DIV_L) ? y_q : x_n;

  wsd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      y_q         <= '0;
      two_q       <= 1'b0;
      res_kind_q  <= wsd_pkg::KIND_FRAME;
      res_left_q  <= '0;
      res_right_q <= '0;
      res_align_q <= 1'b0;
      res_last_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_kind_q  <= wsd_pkg::KIND_FRAME;
      out_left_q  <= '0;
      out_right_q <= '0;
      out_align_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire && err_en) begin
            res_kind_q  <= err_kind;
            res_left_q  <= '0;
            res_right_q <= '0;
            res_align_q <= 1'b0;
            res_last_q  <= 1'b0;
            state_q     <= S_PUSH;
          end else if (in_fire && frame_done) begin
            res_kind_q  <= wsd_pkg::KIND_FRAME;
            y_q         <= y_n;
            two_q       <= c_stereo;
            res_align_q <= c_wide;
            res_last_q  <= last_n;
            state_q     <= S_DIV_L;
          end
        end
        S_DIV_L: begin
          if (div_done) begin
            res_left_q <= div_quot;
            if (two_q) begin
              state_q <= S_DIV_R;
            end else begin
              res_right_q <= div_quot;
              state_q     <= S_PUSH;
            end
          end
        end
        S_DIV_R: begin
          if (div_done) begin
            res_right_q <= div_quot;
            state_q     <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_kind_q  <= res_kind_q;
            out_left_q  <= res_left_q;
            out_right_q <= res_right_q;
            out_align_q <= res_align_q;
            out_last_q  <= res_last_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.kind        = out_kind_q;
  assign out_o.left_value  = out_left_q;
  assign out_o.right_value = out_right_q;
  assign out_o.align_left  = out_align_q;
  assign out_o.last_frame  = out_last_q;

  a_ready_not_dividing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !div_busy)
    else $error("input ready while divider busy");

  a_done_in_div_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV_L || state_q == S_DIV_R))
    else $error("divider result outside a division state");

  a_error_payload_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.kind != wsd_pkg::KIND_FRAME) |->
      (out_o.left_value == '0 && out_o.right_value == '0 && !out_o.last_frame))
    else $error("error result with non-zero payload");

  a_frame_pos_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (fpos_q <= {stereo_q & wide_q, stereo_q | wide_q}))
    else $error("frame position beyond frame size");

endmodule

`default_nettype wire
